// ===== hw/rtl/aifs_pkg.sv =====
// Package for the affine IFS point generator: formats, map codes,
// register indexes and the fixed coefficient table of the four maps.
// No dependencies.
package aifs_pkg;

    // Point format: signed fixed point
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;

    // Coefficients: signed, CF_BITS fraction bits, CF_W bits wide
    localparam int CF_BITS = 20;
    localparam int CF_W    = 22;

    // Accumulator holds two products plus the shifted offset exactly
    localparam int WIDE_BITS = (COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS;
    localparam int ACC_W     = WIDE_BITS + CF_W + 2;
    localparam int PROD_W    = COORD_BITS + CF_W;

    // Saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        ACC_W'(-(64'sd1 <<< (COORD_BITS - 1)));
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(64'sd1 <<< (CF_BITS - 1));

    // Draw and threshold width
    localparam int DRAW_W = 7;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_STEM_LIMIT  = 2'd0,
        REG_LEFT_LIMIT  = 2'd1,
        REG_RIGHT_LIMIT = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    localparam logic [DRAW_W-1:0] STEM_LIMIT_RST  = 7'd1;
    localparam logic [DRAW_W-1:0] LEFT_LIMIT_RST  = 7'd8;
    localparam logic [DRAW_W-1:0] RIGHT_LIMIT_RST = 7'd15;

    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_LEFT  = 2'd1,
        MAP_RIGHT = 2'd2,
        MAP_FROND = 2'd3
    } t_map;

    // x' = ax*x + bx*y + cx ; y' = ay*x + by*y + cy
    typedef struct packed {
        logic signed [CF_W-1:0] ax;
        logic signed [CF_W-1:0] bx;
        logic signed [CF_W-1:0] cx;
        logic signed [CF_W-1:0] ay;
        logic signed [CF_W-1:0] by;
        logic signed [CF_W-1:0] cy;
    } t_coef;

    localparam logic signed [CF_W-1:0] C_ZERO  = 22'sd0;
    localparam logic signed [CF_W-1:0] C_0P2   = 22'sd209715;
    localparam logic signed [CF_W-1:0] C_0P31  = 22'sd325059;
    localparam logic signed [CF_W-1:0] C_0P255 = 22'sd267387;
    localparam logic signed [CF_W-1:0] C_0P245 = 22'sd256901;
    localparam logic signed [CF_W-1:0] C_0P29  = 22'sd304087;
    localparam logic signed [CF_W-1:0] C_0P15  = 22'sd157286;
    localparam logic signed [CF_W-1:0] C_0P24  = 22'sd251658;
    localparam logic signed [CF_W-1:0] C_0P25  = 22'sd262144;
    localparam logic signed [CF_W-1:0] C_0P68  = 22'sd713032;
    localparam logic signed [CF_W-1:0] C_0P845 = 22'sd886047;
    localparam logic signed [CF_W-1:0] C_0P035 = 22'sd36700;
    localparam logic signed [CF_W-1:0] C_0P82  = 22'sd859832;
    localparam logic signed [CF_W-1:0] C_1P6   = 22'sd1677722;

    // Coefficient set of each map
    function automatic t_coef map_coef(input t_map sel);
        t_coef c;
        unique case (sel)
            MAP_STEM:  c = '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_0P2, C_ZERO};
            MAP_LEFT:  c = '{C_0P2, -C_0P31, C_ZERO, C_0P255, C_0P245, C_0P29};
            MAP_RIGHT: c = '{-C_0P15, C_0P24, C_ZERO, C_0P25, C_0P2, C_0P68};
            MAP_FROND: c = '{C_0P845, C_0P035, C_ZERO, -C_0P035, C_0P82, C_1P6};
            default:   c = '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO};
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/affine_ifs_point_generator.sv =====
// Affine IFS point generator top level: map select, multiply-add,
// rounding, saturation, output skid and APB register file.
// Depends on aifs_pkg.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  draw in  | input     | i_valid / o_ready   | i_draw
//  point out| output    | o_valid / i_ready   | o_point_x, o_point_y, o_map_used
//  config   | input     | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// One transaction per cycle while o_ready is high: the current point register
// feeds the map multiply-add, the new point is stored at the same edge it is accepted.
// The output register plus one skid register hold a result accepted under a stall;
// o_ready drops only while the skid register holds a result.
// Synchronous active-low reset clears the point to the origin, empties
// both output stages and loads the default thresholds.
module affine_ifs_point_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [aifs_pkg::DRAW_W-1:0]            i_draw,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [aifs_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [aifs_pkg::COORD_BITS-1:0] o_point_y,
    output logic [1:0]                             o_map_used,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [aifs_pkg::ADDR_W-1:0]            paddr,
    input  logic [aifs_pkg::DATA_W-1:0]            pwdata,
    output logic [aifs_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);
    import aifs_pkg::*;

    // Evaluate a*x + b*y + c, round half up, saturate to the point range
    function automatic logic signed [COORD_BITS-1:0] affine_eval(
        input logic signed [CF_W-1:0]       a,
        input logic signed [CF_W-1:0]       b,
        input logic signed [CF_W-1:0]       c,
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y
    );
        logic signed [PROD_W-1:0] p_a;
        logic signed [PROD_W-1:0] p_b;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  rnd;
        logic signed [ACC_W-1:0]  sat;
        p_a = a * x;
        p_b = b * y;
        acc = ACC_W'(p_a) + ACC_W'(p_b) + (ACC_W'(c) <<< FRAC_BITS);
        rnd = (acc + RND_HALF) >>> CF_BITS;
        if (rnd > SAT_MAX) begin
            sat = SAT_MAX;
        end else if (rnd < SAT_MIN) begin
            sat = SAT_MIN;
        end else begin
            sat = rnd;
        end
        return sat[COORD_BITS-1:0];
    endfunction

    // Registers
    logic [DRAW_W-1:0] r_stem_limit;
    logic [DRAW_W-1:0] r_left_limit;
    logic [DRAW_W-1:0] r_right_limit;

    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    t_map                         r_out_map;

    logic                         r_skid_valid;
    logic signed [COORD_BITS-1:0] r_skid_x;
    logic signed [COORD_BITS-1:0] r_skid_y;
    t_map                         r_skid_map;

    t_map     n_map;
    t_coef    coef;
    logic     in_acc;
    logic     out_free;
    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Map select in priority order, then the multiply-add
    always_comb begin
        priority if (i_draw <= r_stem_limit) begin
            n_map = MAP_STEM;
        end else if (i_draw <= r_left_limit) begin
            n_map = MAP_LEFT;
        end else if (i_draw <= r_right_limit) begin
            n_map = MAP_RIGHT;
        end else begin
            n_map = MAP_FROND;
        end
        coef    = map_coef(n_map);
        n_cur_x = affine_eval(coef.ax, coef.bx, coef.cx, r_cur_x, r_cur_y);
        n_cur_y = affine_eval(coef.ay, coef.by, coef.cy, r_cur_x, r_cur_y);
    end

    // Current point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (in_acc) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    // Output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_map <= r_skid_map;
            end else if (in_acc) begin
                r_out_x   <= n_cur_x;
                r_out_y   <= n_cur_y;
                r_out_map <= n_map;
            end
        end else if (in_acc) begin
            r_skid_x   <= n_cur_x;
            r_skid_y   <= n_cur_y;
            r_skid_map <= n_map;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_point_x  = r_out_x;
    assign o_point_y  = r_out_y;
    assign o_map_used = r_out_map;

    // Register file
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stem_limit  <= STEM_LIMIT_RST;
            r_left_limit  <= LEFT_LIMIT_RST;
            r_right_limit <= RIGHT_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_STEM_LIMIT:  r_stem_limit  <= pwdata[DRAW_W-1:0];
                REG_LEFT_LIMIT:  r_left_limit  <= pwdata[DRAW_W-1:0];
                REG_RIGHT_LIMIT: r_right_limit <= pwdata[DRAW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_STEM_LIMIT:  prdata = DATA_W'(r_stem_limit);
            REG_LEFT_LIMIT:  prdata = DATA_W'(r_left_limit);
            REG_RIGHT_LIMIT: prdata = DATA_W'(r_right_limit);
            default:         prdata = '0;
        endcase
    end

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("transaction accepted under stall not held in skid");

    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && out_free) |=> (o_point_x == r_cur_x && o_point_y == r_cur_y))
        else $error("output point differs from stored point");

    a_stem_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_map_used == MAP_STEM) |-> (o_point_x == '0))
        else $error("stem map produced nonzero x");

endmodule

// ===== test/tb_affine_ifs_point_generator.sv =====
// Testbench for the affine IFS point generator: draws in, fern points out,
// checked against an in-bench fixed-point model of the four maps.
// Depends on aifs_pkg and affine_ifs_point_generator.
`timescale 1ns / 100ps

module tb_affine_ifs_point_generator;
    import aifs_pkg::*;

    localparam int N_DIR = 20;

    // Map coefficients, signed with 20 fraction bits
    localparam longint K_0P2   = 209715;
    localparam longint K_0P31  = 325059;
    localparam longint K_0P255 = 267387;
    localparam longint K_0P245 = 256901;
    localparam longint K_0P29  = 304087;
    localparam longint K_0P15  = 157286;
    localparam longint K_0P24  = 251658;
    localparam longint K_0P25  = 262144;
    localparam longint K_0P68  = 713032;
    localparam longint K_0P845 = 886047;
    localparam longint K_0P035 = 36700;
    localparam longint K_0P82  = 859832;
    localparam longint K_1P6   = 1677722;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        t_map                         map;
    } t_point;

    typedef struct packed {
        logic [DRAW_W-1:0] draw;
        logic              has_fix;
        t_point            fix_pt;
    } t_draw_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [DRAW_W-1:0]            i_draw = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [COORD_BITS-1:0] o_point_x;
    logic signed [COORD_BITS-1:0] o_point_y;
    logic [1:0]                   o_map_used;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ADDR_W-1:0]            paddr = '0;
    logic [DATA_W-1:0]            pwdata = '0;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;

    // Model state: current point and thresholds
    logic signed [COORD_BITS-1:0] fern_x = '0;
    logic signed [COORD_BITS-1:0] fern_y = '0;
    logic [DRAW_W-1:0]            lim_stem = STEM_LIMIT_RST;
    logic [DRAW_W-1:0]            lim_left = LEFT_LIMIT_RST;
    logic [DRAW_W-1:0]            lim_right = RIGHT_LIMIT_RST;

    t_point expected_points [$];
    int     err_count = 0;
    int     tx_burst = 0;
    int     rx_burst = 0;

    // Directed draws at the reset thresholds; fixed rows start from the origin
    t_draw_row dir_rows [N_DIR] = '{
        '{7'd1,   1'b1, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd0,   1'b1, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd127, 1'b1, '{24'sd0, 24'sd104858, MAP_FROND}},
        '{7'd2,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd8,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd9,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd15,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd16,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd100, 1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd1,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd64,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd50,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd99,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd101, 1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd3,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd12,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd7,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd13,  1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd127, 1'b0, '{24'sd0, 24'sd0, MAP_STEM}},
        '{7'd0,   1'b0, '{24'sd0, 24'sd0, MAP_STEM}}
    };

    affine_ifs_point_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_draw     (i_draw),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_map_used (o_map_used),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // a*x + b*y + c, round half up to FRAC_BITS, saturate to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] affine_eval(
        input longint a, input longint b, input longint c,
        input longint x, input longint y);
        longint acc;
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        acc = a * x + b * y + (c <<< FRAC_BITS);
        r = (acc + (longint'(1) <<< (CF_BITS - 1))) >>> CF_BITS;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[COORD_BITS-1:0];
    endfunction

    // Next fern point from the current one; thresholds tested in priority order
    function automatic t_point next_fern_point(input logic [DRAW_W-1:0] d);
        t_point p;
        if (d <= lim_stem) p.map = MAP_STEM;
        else if (d <= lim_left) p.map = MAP_LEFT;
        else if (d <= lim_right) p.map = MAP_RIGHT;
        else p.map = MAP_FROND;
        case (p.map)
            MAP_STEM: begin
                p.x = '0;
                p.y = affine_eval(0, K_0P2, 0, fern_x, fern_y);
            end
            MAP_LEFT: begin
                p.x = affine_eval(K_0P2, -K_0P31, 0, fern_x, fern_y);
                p.y = affine_eval(K_0P255, K_0P245, K_0P29, fern_x, fern_y);
            end
            MAP_RIGHT: begin
                p.x = affine_eval(-K_0P15, K_0P24, 0, fern_x, fern_y);
                p.y = affine_eval(K_0P25, K_0P2, K_0P68, fern_x, fern_y);
            end
            default: begin
                p.x = affine_eval(K_0P845, K_0P035, 0, fern_x, fern_y);
                p.y = affine_eval(-K_0P035, K_0P82, K_1P6, fern_x, fern_y);
            end
        endcase
        return p;
    endfunction

    // Idle count per transaction, with occasional back-to-back bursts
    function automatic int pick_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Mostly nominal draws, some outside 1..100
    function automatic logic [DRAW_W-1:0] rand_draw();
        if ($urandom_range(0, 19) == 0) return DRAW_W'($urandom_range(0, 127));
        return DRAW_W'($urandom_range(1, 100));
    endfunction

    // Called and returns at a falling edge; valid stays up when the next
    // transaction follows without a gap
    task automatic send_draw(input logic [DRAW_W-1:0] d, input logic has_fix,
                             input t_point fix_pt);
        int     gap;
        t_point p;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_draw  <= d;
        do @(posedge i_clk); while (!o_ready);
        p = next_fern_point(d);
        fern_x = p.x;
        fern_y = p.y;
        expected_points.push_back(has_fix ? fix_pt : p);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_draw(rand_draw(), 1'b0, '0);
    endtask

    // Stop sending and wait for every expected point to come out
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Setup, access, then an idle phase; returns at a falling edge
    task automatic apb_write(input t_reg_idx idx, input logic [DRAW_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_STEM_LIMIT:  lim_stem = val;
            REG_LEFT_LIMIT:  lim_left = val;
            REG_RIGHT_LIMIT: lim_right = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_check(input t_reg_idx idx, input logic [DRAW_W-1:0] exp_val);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(idx) * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (got !== DATA_W'(exp_val)) begin
            $error("prdata[%s]: expected %0d, got %0d", idx.name(), exp_val, got);
            err_count++;
        end
    endtask

    task automatic set_limits(input logic [DRAW_W-1:0] s, input logic [DRAW_W-1:0] l,
                              input logic [DRAW_W-1:0] r);
        apb_write(REG_STEM_LIMIT, s);
        apb_write(REG_LEFT_LIMIT, l);
        apb_write(REG_RIGHT_LIMIT, r);
        apb_check(REG_STEM_LIMIT, lim_stem);
        apb_check(REG_LEFT_LIMIT, lim_left);
        apb_check(REG_RIGHT_LIMIT, lim_right);
    endtask

    // Result consumer: random stalls per transaction
    initial begin : point_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = pick_gap(rx_burst);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Compare each output transaction with the oldest expected point
    always @(posedge i_clk) begin : point_check
        t_point e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point: x %0d y %0d map %0d",
                       o_point_x, o_point_y, o_map_used);
                err_count++;
            end else begin
                e = expected_points.pop_front();
                if (o_point_x !== e.x) begin
                    $error("point_x: expected %0d, got %0d", e.x, o_point_x);
                    err_count++;
                end
                if (o_point_y !== e.y) begin
                    $error("point_y: expected %0d, got %0d", e.y, o_point_y);
                    err_count++;
                end
                if (o_map_used !== 2'(e.map)) begin
                    $error("map_used: expected %0d, got %0d", e.map, o_map_used);
                    err_count++;
                end
            end
        end
    end

    initial begin : run
        int i;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset thresholds read back, then directed draws
        apb_check(REG_STEM_LIMIT, STEM_LIMIT_RST);
        apb_check(REG_LEFT_LIMIT, LEFT_LIMIT_RST);
        apb_check(REG_RIGHT_LIMIT, RIGHT_LIMIT_RST);
        for (i = 0; i < N_DIR; i++)
            send_draw(dir_rows[i].draw, dir_rows[i].has_fix, dir_rows[i].fix_pt);
        send_random(180);
        drain();

        // Extremes: only draw 0 is stem, then nearly everything is stem
        set_limits(7'd0, 7'd0, 7'd0);
        send_random(60);
        drain();
        set_limits(7'd100, 7'd100, 7'd100);
        send_random(60);
        drain();

        // Non-increasing thresholds hide the left or the right pinna
        set_limits(7'd40, 7'd20, 7'd70);
        send_random(60);
        drain();
        set_limits(7'd10, 7'd90, 7'd50);
        send_random(60);
        drain();

        // Random settings, sorted or not
        repeat (4) begin
            set_limits(DRAW_W'($urandom_range(0, 100)), DRAW_W'($urandom_range(0, 100)),
                       DRAW_W'($urandom_range(0, 100)));
            send_random(50);
            drain();
        end

        // Unmapped address must leave the thresholds alone
        apb_write(REG_NONE, 7'h55);
        apb_check(REG_STEM_LIMIT, lim_stem);
        apb_check(REG_LEFT_LIMIT, lim_left);
        apb_check(REG_RIGHT_LIMIT, lim_right);
        set_limits(STEM_LIMIT_RST, LEFT_LIMIT_RST, RIGHT_LIMIT_RST);
        send_random(30);
        drain();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/aifs_pkg.sv
hw/rtl/affine_ifs_point_generator.sv
test/tb_affine_ifs_point_generator.sv
